### rtl/ktsa_pkg.sv
// ----------------------------------------------------------------------------
// ktsa_pkg
// Shared sizes, codes and controller/datapath interface types for the keyed
// toggle slot allocator.
// ----------------------------------------------------------------------------
package ktsa_pkg;

   // table geometry
   localparam int NUM_SLOTS = 32;
   localparam int KEY_BITS  = 64;

   // slot index and occupancy counter widths
   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);

   // fixed widths of the request and response fields
   localparam int REQ_KEY_W = 64;
   localparam int STATUS_W  = 2;
   localparam int SLOT_W    = 6;
   localparam int COUNT_W   = 6;

   // response status codes
   localparam logic [STATUS_W-1:0] RSP_ALLOC = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_FREE  = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_FULL  = 2'd2;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } ktsa_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;    // capture key, restart scan
      logic scan;    // step the table scan
      logic commit;  // update table, emit response
   } ktsa_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_done;
   } ktsa_sts_type;

endpackage

### rtl/ktsa_ctrl.sv
// ----------------------------------------------------------------------------
// ktsa_ctrl
// Request sequencer: idle, table scan, commit. Drives the datapath commands
// and the busy flag.
// ----------------------------------------------------------------------------
module ktsa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output ktsa_pkg::ktsa_cmd_type cmd,
   input  ktsa_pkg::ktsa_sts_type sts
);
   import ktsa_pkg::*;

   ktsa_state_type state_ff;
   ktsa_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // a commit always follows a finished scan
   a_commit_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $past(sts.scan_done && cmd.scan))
      else $error("commit without finished scan");

endmodule

### rtl/ktsa_dpath.sv
// ----------------------------------------------------------------------------
// ktsa_dpath
// Slot table datapath: owner key memory, occupied flags, scan counter with
// first-match and first-free trackers, occupancy count and response register.
// ----------------------------------------------------------------------------
module ktsa_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  ktsa_pkg::ktsa_cmd_type         cmd,
   output ktsa_pkg::ktsa_sts_type         sts,
   input  logic [ktsa_pkg::REQ_KEY_W-1:0] req_request_key,
   output logic                           rsp_valid,
   output logic [ktsa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ktsa_pkg::SLOT_W-1:0]    rsp_slot_number,
   output logic [ktsa_pkg::COUNT_W-1:0]   rsp_occupied_count
);
   import ktsa_pkg::*;

   // owner key memory, valid only where the occupied flag is set
   logic [KEY_BITS-1:0] owner_mem [NUM_SLOTS];
   logic [KEY_BITS-1:0] rdata_ff;

   logic [NUM_SLOTS-1:0] busy_ff;
   logic [CNT_W-1:0]     total_ff;
   logic [KEY_BITS-1:0]  key_ff;

   // scan state
   logic [CNT_W-1:0] rd_cnt_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             cmp_vld_ff;
   logic             hit_found_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic             free_found_ff;
   logic [IDX_W-1:0] free_idx_ff;

   // response registers
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic rd_more;
   logic cmp_hit;
   logic cmp_free;

   assign rd_more  = cmd.scan && (rd_cnt_ff != CNT_W'(NUM_SLOTS));
   assign cmp_hit  = cmp_vld_ff && busy_ff[cmp_idx_ff] && (rdata_ff == key_ff);
   assign cmp_free = cmp_vld_ff && !busy_ff[cmp_idx_ff];

   assign sts.scan_done = (rd_cnt_ff == CNT_W'(NUM_SLOTS)) && !cmp_vld_ff;

   // key memory: write on allocate, read one slot per scan step
   always_ff @(posedge clock) begin
      if (cmd.commit && !hit_found_ff && free_found_ff) begin
         owner_mem[free_idx_ff] <= key_ff;
      end
      if (rd_more) begin
         rdata_ff <= owner_mem[rd_cnt_ff[IDX_W-1:0]];
      end
   end

   // request key capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= req_request_key[KEY_BITS-1:0];
      end
   end

   // scan counter and compare stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff     <= '0;
         cmp_vld_ff    <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.load) begin
         rd_cnt_ff     <= '0;
         cmp_vld_ff    <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= rd_more;
         if (rd_more) begin
            rd_cnt_ff <= rd_cnt_ff + CNT_W'(1);
         end
         if (cmp_hit && !hit_found_ff) begin
            hit_found_ff <= 1'b1;
         end
         if (cmp_free && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   // compare index and first-match / first-free slot numbers
   always_ff @(posedge clock) begin
      if (rd_more) begin
         cmp_idx_ff <= rd_cnt_ff[IDX_W-1:0];
      end
      if (cmp_hit && !hit_found_ff) begin
         hit_idx_ff <= cmp_idx_ff;
      end
      if (cmp_free && !free_found_ff) begin
         free_idx_ff <= cmp_idx_ff;
      end
   end

   // occupied flags and count
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= '0;
         total_ff <= '0;
      end else if (cmd.commit) begin
         priority if (hit_found_ff) begin
            busy_ff[hit_idx_ff] <= 1'b0;
            total_ff            <= total_ff - CNT_W'(1);
         end else if (free_found_ff) begin
            busy_ff[free_idx_ff] <= 1'b1;
            total_ff             <= total_ff + CNT_W'(1);
         end else begin
            busy_ff  <= busy_ff;
         end
      end
   end

   // response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         priority if (hit_found_ff) begin
            rsp_status_ff <= RSP_FREE;
            rsp_slot_ff   <= SLOT_W'({1'b0, hit_idx_ff} + (IDX_W + 1)'(1));
            rsp_count_ff  <= COUNT_W'(total_ff - CNT_W'(1));
         end else if (free_found_ff) begin
            rsp_status_ff <= RSP_ALLOC;
            rsp_slot_ff   <= SLOT_W'({1'b0, free_idx_ff} + (IDX_W + 1)'(1));
            rsp_count_ff  <= COUNT_W'(total_ff + CNT_W'(1));
         end else begin
            rsp_status_ff <= RSP_FULL;
            rsp_slot_ff   <= '0;
            rsp_count_ff  <= COUNT_W'(total_ff);
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot_number    = rsp_slot_ff;
   assign rsp_occupied_count = rsp_count_ff;

   // count tracks the occupied flags
   a_total_matches_flags: assert property (@(posedge clock) disable iff (reset)
      total_ff == CNT_W'($countones(busy_ff)))
      else $error("occupancy count out of step with flags");

   // a rejected request leaves the table untouched
   a_full_no_change: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !hit_found_ff && !free_found_ff |=> $stable(busy_ff))
      else $error("full table changed on reject");

   // a strobe only follows a commit
   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.commit))
      else $error("response without commit");

endmodule

### rtl/keyed_toggle_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// keyed_toggle_slot_allocator_top
// Keyed slot table: a request frees the slot its key holds, else takes the
// lowest free slot, else is rejected as full.
//
//   channel   ports                                   handshake
//   request   req_request_key                         start && !busy
//   response  rsp_status, rsp_slot_number,            rsp_valid, one cycle
//             rsp_occupied_count
//
// A request is answered after a scan of the key memory, one slot per
// cycle, and a commit. The response strobe shows in the first cycle with
// busy low; a new request may be accepted at the edge that ends it, so the
// allocator takes no new request before the last one is answered. Reset
// clears all occupied flags at once. The response side cannot stall.
// ----------------------------------------------------------------------------
module keyed_toggle_slot_allocator_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [ktsa_pkg::REQ_KEY_W-1:0] req_request_key,
   output logic                           rsp_valid,
   output logic [ktsa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ktsa_pkg::SLOT_W-1:0]    rsp_slot_number,
   output logic [ktsa_pkg::COUNT_W-1:0]   rsp_occupied_count
);
   import ktsa_pkg::*;

   ktsa_cmd_type cmd;
   ktsa_sts_type sts;

   // sequencer
   ktsa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   // slot table datapath
   ktsa_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_request_key    (req_request_key),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_slot_number    (rsp_slot_number),
      .rsp_occupied_count (rsp_occupied_count)
   );

endmodule
